/* src/nfcp_pkg.sv */
// Shared types, constants and helpers of the fixed-column sentence parser.
package nfcp_pkg;

   // Line store geometry; the column saturates at the last slot.
   localparam int LINE_DEPTH = 64;
   localparam int COL_W      = $clog2(LINE_DEPTH);

   // Only these columns are ever read back, so only they are kept.
   localparam int NUM_TAPS = 28;
   localparam int TAP_W    = $clog2(NUM_TAPS);
   localparam int TAP_COL [NUM_TAPS] = '{4, 5, 7, 9, 17, 18, 19, 20, 22, 23, 24, 25, 26, 28,
                                         30, 31, 32, 33, 34, 36, 37, 38, 39, 40, 42, 44, 46,
                                         47};

   localparam int COL_TALK0     = 4;
   localparam int COL_TALK1     = 5;
   localparam int COL_GLL_SEP   = 7;
   localparam int COL_GSA_FIX   = 9;
   localparam int COL_NS        = 28;
   localparam int COL_EW        = 42;
   localparam int COL_GGA_FIX   = 44;
   localparam int COL_SAT_TENS  = 46;
   localparam int COL_SAT_UNITS = 47;

   localparam int LO_DIGITS     = 7;
   localparam int HI_DIGITS     = 3;
   localparam int LAT_HI_DIGITS = 2;
   localparam int LAT_LO_COL [LO_DIGITS]     = '{19, 20, 22, 23, 24, 25, 26};
   localparam int LAT_HI_COL [LAT_HI_DIGITS] = '{17, 18};
   localparam int LON_LO_COL [LO_DIGITS]     = '{33, 34, 36, 37, 38, 39, 40};
   localparam int LON_HI_COL [HI_DIGITS]     = '{30, 31, 32};

   // Digit weights; element 0 is the most significant digit of each group.
   localparam logic [LO_DIGITS-1:0][31:0] LO_WEIGHT = {
      32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000, 32'd10000000};
   localparam logic [HI_DIGITS-1:0][31:0] LAT_HI_WEIGHT = {
      32'd0, 32'd10000000, 32'd100000000};
   localparam logic [HI_DIGITS-1:0][31:0] LON_HI_WEIGHT = {
      32'd10000000, 32'd100000000, 32'd1000000000};

   // Reciprocals for exact unsigned division of values below 2**32.
   localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
   localparam int          RECIP3_SHIFT = 33;
   localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
   localparam int          RECIP5_SHIFT = 34;
   localparam int          PROD_W       = 63;

   localparam int PIPE_STAGES = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_E      = 8'h45;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_L      = 8'h4C;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_S      = 8'h53;

   typedef logic [TAP_W-1:0] tap_idx_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_GGA   = 2'd1,
      KIND_GSA   = 2'd2,
      KIND_GLL   = 2'd3
   } kind_type;

   // Everything the back end needs from one finished sentence.
   typedef struct packed {
      kind_type                          kind;
      logic                              north;
      logic                              east;
      logic signed [12:0]                sat;
      logic signed [8:0]                 fix;
      logic [LO_DIGITS-1:0][8:0]         lat_lo;
      logic [LAT_HI_DIGITS-1:0][8:0]     lat_hi;
      logic [LO_DIGITS-1:0][8:0]         lon_lo;
      logic [HI_DIGITS-1:0][8:0]         lon_hi;
   } entry_type;

   // Fields that ride alongside the position arithmetic.
   typedef struct packed {
      kind_type           kind;
      logic               north;
      logic               east;
      logic signed [12:0] sat;
      logic signed [8:0]  fix;
   } side_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Tap slot that holds a given line column.
   function automatic tap_idx_type tap_idx(input int col);
      tap_idx_type r;
      r = '0;
      for (int k = 0; k < NUM_TAPS; k++) begin
         if (TAP_COL[k] == col) begin
            r = TAP_W'(k);
         end
      end
      return r;
   endfunction

   // Character weighted as byte minus ASCII zero, two's complement in 9 bits.
   function automatic logic [8:0] dig(input logic [7:0] c);
      return {1'b0, c} - {1'b0, CH_ZERO};
   endfunction

endpackage

/* src/nfcp_if.sv */
// Valid/ready channel interfaces for received bytes and decoded results.
interface nfcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nfcp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         sentence_kind;
   logic signed [28:0] latitude;
   logic signed [28:0] longitude;
   logic               north_flag;
   logic               east_flag;
   logic signed [12:0] sat_count;
   logic signed [8:0]  fix_type;

   modport source (output valid, output sentence_kind, output latitude, output longitude,
                   output north_flag, output east_flag, output sat_count, output fix_type,
                   input ready);
   modport sink   (input valid, input sentence_kind, input latitude, input longitude,
                   input north_flag, input east_flag, input sat_count, input fix_type,
                   output ready);
endinterface

/* src/nfcp_front.sv */
// Front end: column tracking, line store taps and sentence classification.
module nfcp_front (
   input  logic                       clock,
   input  logic                       reset,
   nfcp_req_if.sink                   req,
   input  nfcp_pkg::q_status_type     q_status,
   output logic                       push,
   output nfcp_pkg::entry_type        entry
);

   logic [nfcp_pkg::COL_W-1:0] col_ff, col_in;
   logic [7:0]                 tap_ff [nfcp_pkg::NUM_TAPS];
   logic [7:0]                 tap_in [nfcp_pkg::NUM_TAPS];
   logic                       accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && (req.rx_byte == nfcp_pkg::CH_STAR);

   always_comb begin
      col_in = col_ff;
      tap_in = tap_ff;
      if (accept) begin
         if (req.rx_byte == nfcp_pkg::CH_DOLLAR) begin
            // restart the line: column 0 holds the '$', no tap sits there
            col_in = '0;
            for (int k = 0; k < nfcp_pkg::NUM_TAPS; k++) begin
               tap_in[k] = nfcp_pkg::CH_DASH;
            end
         end else begin
            if (col_ff < nfcp_pkg::COL_W'(nfcp_pkg::LINE_DEPTH - 1)) begin
               col_in = col_ff + nfcp_pkg::COL_W'(1);
            end
            for (int k = 0; k < nfcp_pkg::NUM_TAPS; k++) begin
               if (col_in == nfcp_pkg::COL_W'(nfcp_pkg::TAP_COL[k])) begin
                  tap_in[k] = req.rx_byte;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         for (int k = 0; k < nfcp_pkg::NUM_TAPS; k++) begin
            tap_ff[k] <= '0;
         end
      end else begin
         col_ff <= col_in;
         tap_ff <= tap_in;
      end
   end

   // Classify from the line as it stands once the closing '*' is stored.
   always_comb begin
      logic [7:0]         t4, t5, t7, t44;
      logic signed [12:0] tens, units;
      t4  = tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_TALK0)];
      t5  = tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_TALK1)];
      t7  = tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_GLL_SEP)];
      t44 = tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_GGA_FIX)];
      tens  = 13'(signed'(nfcp_pkg::dig(tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_SAT_TENS)])));
      units = 13'(signed'(nfcp_pkg::dig(tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_SAT_UNITS)])));

      entry       = '0;
      entry.kind  = nfcp_pkg::KIND_OTHER;
      if (t4 == nfcp_pkg::CH_L && t5 == nfcp_pkg::CH_L && t7 == nfcp_pkg::CH_COMMA) begin
         entry.kind = nfcp_pkg::KIND_GLL;
      end else if (t4 == nfcp_pkg::CH_G && t5 == nfcp_pkg::CH_A &&
                   (t44 inside {nfcp_pkg::CH_ONE, nfcp_pkg::CH_TWO})) begin
         entry.kind  = nfcp_pkg::KIND_GGA;
         entry.north = (tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_NS)] == nfcp_pkg::CH_N);
         entry.east  = (tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_EW)] == nfcp_pkg::CH_E);
         entry.sat   = tens * 13'sd10 + units;
      end else if (t4 == nfcp_pkg::CH_S && t5 == nfcp_pkg::CH_A) begin
         entry.kind = nfcp_pkg::KIND_GSA;
         entry.fix  = signed'(nfcp_pkg::dig(tap_in[nfcp_pkg::tap_idx(nfcp_pkg::COL_GSA_FIX)]));
      end

      for (int k = 0; k < nfcp_pkg::LO_DIGITS; k++) begin
         entry.lat_lo[k] = nfcp_pkg::dig(tap_in[nfcp_pkg::tap_idx(nfcp_pkg::LAT_LO_COL[k])]);
         entry.lon_lo[k] = nfcp_pkg::dig(tap_in[nfcp_pkg::tap_idx(nfcp_pkg::LON_LO_COL[k])]);
      end
      for (int k = 0; k < nfcp_pkg::LAT_HI_DIGITS; k++) begin
         entry.lat_hi[k] = nfcp_pkg::dig(tap_in[nfcp_pkg::tap_idx(nfcp_pkg::LAT_HI_COL[k])]);
      end
      for (int k = 0; k < nfcp_pkg::HI_DIGITS; k++) begin
         entry.lon_hi[k] = nfcp_pkg::dig(tap_in[nfcp_pkg::tap_idx(nfcp_pkg::LON_HI_COL[k])]);
      end
   end

endmodule

/* src/nfcp_queue.sv */
// Short sentence queue between the front end and the arithmetic back end.
module nfcp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nfcp_pkg::entry_type        push_data,
   input  logic                       pop,
   output nfcp_pkg::entry_type        head,
   output nfcp_pkg::q_status_type     q_status
);

   nfcp_pkg::entry_type           mem_ff [nfcp_pkg::QUEUE_DEPTH];
   logic [nfcp_pkg::QUEUE_AW-1:0] wr_ff, wr_in;
   logic [nfcp_pkg::QUEUE_AW-1:0] rd_ff, rd_in;
   logic [nfcp_pkg::QUEUE_CW-1:0] count_ff, count_in;

   assign head           = mem_ff[rd_ff];
   assign q_status.full  = (count_ff == nfcp_pkg::QUEUE_CW'(nfcp_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == nfcp_pkg::QUEUE_AW'(nfcp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ff + nfcp_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == nfcp_pkg::QUEUE_AW'(nfcp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ff + nfcp_pkg::QUEUE_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + nfcp_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - nfcp_pkg::QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* src/nfcp_pos.sv */
// Eight-stage coordinate pipeline: weighted digit sums, divide by 6, divide by 10.
module nfcp_pos (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic [nfcp_pkg::LO_DIGITS-1:0][8:0]       lo_dig,
   input  logic [nfcp_pkg::HI_DIGITS-1:0][8:0]       hi_dig,
   input  logic [nfcp_pkg::HI_DIGITS-1:0][31:0]      hi_weight,
   output logic [28:0]                               quot,
   output logic                                      neg
);

   logic [31:0] p_lo_ff [nfcp_pkg::LO_DIGITS];
   logic [31:0] p_hi_ff [nfcp_pkg::HI_DIGITS];
   logic [31:0] a0_ff, a1_ff, h2_ff;
   logic [31:0] s3_ff, h3_ff;
   logic [30:0] half4_ff;
   logic        neg4_ff;
   logic [31:0] h4_ff;
   logic [29:0] q5_ff;
   logic        neg5_ff;
   logic [31:0] h5_ff;
   logic [31:0] t6_ff;
   logic [30:0] half7_ff;
   logic        neg7_ff;
   logic [28:0] q8_ff;
   logic        neg8_ff;

   logic [31:0]                 m4, m7, qs6;
   logic [nfcp_pkg::PROD_W-1:0] prod5, prod8;

   assign m4    = s3_ff[31] ? (~s3_ff + 32'd1) : s3_ff;
   assign prod5 = {32'd0, half4_ff} * {31'd0, nfcp_pkg::RECIP3};
   assign qs6   = neg5_ff ? (32'd0 - {2'b00, q5_ff}) : {2'b00, q5_ff};
   assign m7    = t6_ff[31] ? (~t6_ff + 32'd1) : t6_ff;
   assign prod8 = {32'd0, half7_ff} * {31'd0, nfcp_pkg::RECIP5};

   always_ff @(posedge clock) begin
      if (en) begin
         // digits are two's complement; products wrap at 32 bits
         for (int k = 0; k < nfcp_pkg::LO_DIGITS; k++) begin
            p_lo_ff[k] <= {{23{lo_dig[k][8]}}, lo_dig[k]} * nfcp_pkg::LO_WEIGHT[k];
         end
         for (int k = 0; k < nfcp_pkg::HI_DIGITS; k++) begin
            p_hi_ff[k] <= {{23{hi_dig[k][8]}}, hi_dig[k]} * hi_weight[k];
         end
         a0_ff <= p_lo_ff[0] + p_lo_ff[1] + p_lo_ff[2] + p_lo_ff[3];
         a1_ff <= p_lo_ff[4] + p_lo_ff[5] + p_lo_ff[6];
         h2_ff <= p_hi_ff[0] + p_hi_ff[1] + p_hi_ff[2];
         s3_ff <= a0_ff + a1_ff;
         h3_ff <= h2_ff;
         // truncating signed divide by 6: halve the magnitude, then divide by 3
         half4_ff <= m4[31:1];
         neg4_ff  <= s3_ff[31];
         h4_ff    <= h3_ff;
         q5_ff    <= prod5[nfcp_pkg::PROD_W-1:nfcp_pkg::RECIP3_SHIFT];
         neg5_ff  <= neg4_ff;
         h5_ff    <= h4_ff;
         t6_ff    <= qs6 + h5_ff;
         // truncating signed divide by 10: halve the magnitude, then divide by 5
         half7_ff <= m7[31:1];
         neg7_ff  <= t6_ff[31];
         q8_ff    <= prod8[nfcp_pkg::PROD_W-1:nfcp_pkg::RECIP5_SHIFT];
         neg8_ff  <= neg7_ff;
      end
   end

   assign quot = q8_ff;
   assign neg  = neg8_ff;

endmodule

/* src/nfcp_back.sv */
// Back end: pops sentences, runs both coordinate pipelines and holds the result beat.
module nfcp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  nfcp_pkg::entry_type        head,
   input  nfcp_pkg::q_status_type     q_status,
   output logic                       pop,
   nfcp_rsp_if.source                 rsp
);

   logic                 en;
   logic                 valid_ff [nfcp_pkg::PIPE_STAGES];
   logic                 valid_in [nfcp_pkg::PIPE_STAGES];
   nfcp_pkg::side_type   side_ff  [nfcp_pkg::PIPE_STAGES];
   nfcp_pkg::side_type   side_head;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           kind_ff;
   logic signed [28:0]   lat_ff, lon_ff;
   logic                 north_ff, east_ff;
   logic signed [12:0]   sat_ff;
   logic signed [8:0]    fix_ff;
   logic [28:0]          lat_q, lon_q;
   logic                 lat_neg, lon_neg;
   logic                 gga;

   // advance the whole pipe whenever the output register is free or being drained
   assign en  = !rsp_valid_ff || rsp.ready;
   assign pop = en && !q_status.empty;

   assign side_head.kind  = head.kind;
   assign side_head.north = head.north;
   assign side_head.east  = head.east;
   assign side_head.sat   = head.sat;
   assign side_head.fix   = head.fix;

   nfcp_pos u_lat (
      .clock     (clock),
      .en        (en),
      .lo_dig    (head.lat_lo),
      .hi_dig    ({9'd0, head.lat_hi}),
      .hi_weight (nfcp_pkg::LAT_HI_WEIGHT),
      .quot      (lat_q),
      .neg       (lat_neg)
   );

   nfcp_pos u_lon (
      .clock     (clock),
      .en        (en),
      .lo_dig    (head.lon_lo),
      .hi_dig    (head.lon_hi),
      .hi_weight (nfcp_pkg::LON_HI_WEIGHT),
      .quot      (lon_q),
      .neg       (lon_neg)
   );

   always_comb begin
      for (int k = 0; k < nfcp_pkg::PIPE_STAGES; k++) begin
         valid_in[k] = valid_ff[k];
      end
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         valid_in[0] = !q_status.empty;
         for (int k = 1; k < nfcp_pkg::PIPE_STAGES; k++) begin
            valid_in[k] = valid_ff[k-1];
         end
         rsp_valid_in = valid_ff[nfcp_pkg::PIPE_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < nfcp_pkg::PIPE_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign gga = (side_ff[nfcp_pkg::PIPE_STAGES-1].kind == nfcp_pkg::KIND_GGA);

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_head;
         for (int k = 1; k < nfcp_pkg::PIPE_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         kind_ff  <= side_ff[nfcp_pkg::PIPE_STAGES-1].kind;
         north_ff <= side_ff[nfcp_pkg::PIPE_STAGES-1].north;
         east_ff  <= side_ff[nfcp_pkg::PIPE_STAGES-1].east;
         sat_ff   <= side_ff[nfcp_pkg::PIPE_STAGES-1].sat;
         fix_ff   <= side_ff[nfcp_pkg::PIPE_STAGES-1].fix;
         // restore the sign; position is zero for anything but a GGA fix
         lat_ff   <= !gga ? 29'sd0 : signed'(lat_neg ? (29'd0 - lat_q) : lat_q);
         lon_ff   <= !gga ? 29'sd0 : signed'(lon_neg ? (29'd0 - lon_q) : lon_q);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.sentence_kind = kind_ff;
   assign rsp.latitude      = lat_ff;
   assign rsp.longitude     = lon_ff;
   assign rsp.north_flag    = north_ff;
   assign rsp.east_flag     = east_ff;
   assign rsp.sat_count     = sat_ff;
   assign rsp.fix_type      = fix_ff;

endmodule

/* src/nmea_fixed_column_parser_top.sv */
// Top level of the fixed-column GPS sentence parser.
//
// req_ch carries one received ASCII byte per beat; rsp_ch carries one decoded
// result per sentence, produced when the closing '*' is taken. A '$' restarts
// the line at column 0; other bytes advance the column, which sticks at the
// last slot of the line store.
// Throughput: one byte per cycle on req_ch while the queue has room, one result
// per cycle on rsp_ch while rsp_ch is ready. A result passes from its '*' beat
// through the sentence queue, the eight register stages of the coordinate
// pipeline (two reciprocal multiplies) and the result register to rsp_ch.
// A two-entry sentence queue sits between the byte front end and the pipeline.
// When rsp_ch stalls, the result holds and the pipeline freezes; bytes keep
// flowing until two sentences wait in the queue, then req_ch.ready drops.
// Reset (synchronous, active high) clears the column, the stored line and all
// valid state; no result is pending after it.
module nmea_fixed_column_parser_top (
   input  logic        clock,
   input  logic        reset,
   nfcp_req_if.sink    req_ch,
   nfcp_rsp_if.source  rsp_ch
);

   logic                   push;
   logic                   pop;
   nfcp_pkg::entry_type    entry;
   nfcp_pkg::entry_type    head;
   nfcp_pkg::q_status_type q_status;

   nfcp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_status (q_status),
      .push     (push),
      .entry    (entry)
   );

   nfcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   nfcp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

/* src/nfcp_checker.sv */
// Port-level checks on the parser's result channel, bound to the top level.
module nfcp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         kind,
   input logic signed [28:0] lat,
   input logic signed [28:0] lon,
   input logic               north,
   input logic               east,
   input logic signed [12:0] sat,
   input logic signed [8:0]  fix
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(lat) && $stable(lon))
      else $error("result beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_pos_only_gga: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != nfcp_pkg::KIND_GGA |-> lat == 0 && lon == 0 && !north && !east
                                                  && sat == 0)
      else $error("position fields set on a sentence without a fix");

   a_fix_only_gsa: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != nfcp_pkg::KIND_GSA |-> fix == 0)
      else $error("fix type set on a sentence other than GSA");

endmodule

bind nmea_fixed_column_parser_top nfcp_checker u_nfcp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .kind      (rsp_ch.sentence_kind),
   .lat       (rsp_ch.latitude),
   .lon       (rsp_ch.longitude),
   .north     (rsp_ch.north_flag),
   .east      (rsp_ch.east_flag),
   .sat       (rsp_ch.sat_count),
   .fix       (rsp_ch.fix_type)
);
